>>> src/windowed_spi_register_sequencer_macros.svh
// Assertion macros for the windowed SPI register sequencer.
// Used by wsrs_seq in src; expects clk and rst_n in the using module.
`ifndef WINDOWED_SPI_REGISTER_SEQUENCER_MACROS_SVH
`define WINDOWED_SPI_REGISTER_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define WSRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen at a clock edge out of reset
`define WSRS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define WSRS_ASSERT(lbl, prop, msg)
`define WSRS_NEVER(lbl, expr, msg)
`endif
`endif

>>> src/wsrs_pkg.sv
// Shared types and constants for the windowed SPI register sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsrs_pkg;

    // field widths
    localparam int ADDR_W  = 7;
    localparam int GAP_W   = 16;
    localparam int VALUE_W = 16;
    localparam int WIN_W   = 8;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // hard cap on any run of address or dummy frames
    localparam int RUN_LIMIT = 16;

    // defaults for the top level parameters
    localparam int DEF_MAX_READ_WORDS  = 8;
    localparam int DEF_MAX_BURST_WORDS = 16;
    localparam int DEF_WINDOW_REG_ADDR = 126;

    // register reset values
    localparam logic [GAP_W-1:0] SHORT_GAP_RESET = 16'd30;
    localparam logic [GAP_W-1:0] BURST_GAP_RESET = 16'd45;
    localparam logic [CNT_W-1:0] BURST_WORDS_RESET = 5'd8;

    // write flag in bit 15 of a frame
    localparam logic [VALUE_W-1:0] WRITE_FLAG = 16'h8000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_GAP   = 2'd0,
        CFG_BURST_GAP   = 2'd1,
        CFG_BURST_WORDS = 2'd2
    } cfg_index_t;

    // request operation codes
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_BURST  = 2'd2,
        OP_FORGET = 2'd3
    } op_t;

    // frame kinds on the output
    typedef enum logic [2:0] {
        KIND_WIN    = 3'd0,
        KIND_RADDR  = 3'd1,
        KIND_RDUMMY = 3'd2,
        KIND_WRITE  = 3'd3,
        KIND_BCMD   = 3'd4,
        KIND_BDUMMY = 3'd5
    } kind_t;

    // sequencer states: idle, plus one per frame phase
    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_RADDR,
        S_RDUMMY,
        S_WLO,
        S_WHI,
        S_BCMD,
        S_BDUMMY
    } state_t;

    // sequencer to frame unit
    typedef struct packed {
        logic               step;
        state_t             phase;
        logic [ADDR_W-1:0]  addr;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        logic [WIN_W-1:0]   window;
        logic               win_final;
        logic               hi_pending;
        logic               idx_final;
    } seq_ctrl_t;

    // one formatted frame
    typedef struct packed {
        logic [VALUE_W-1:0] word;
        kind_t              kind;
        logic [GAP_W-1:0]   gap;
        logic               release_cs;
        logic               fin;
    } frame_t;

endpackage

`default_nettype wire

>>> src/wsrs_frame_unit.sv
// Frame formatter with the shared 7-bit address adder.
// Depends on wsrs_pkg; driven by wsrs_seq control each cycle.
`default_nettype none

module wsrs_frame_unit #(
    parameter int WINDOW_REG_ADDR = wsrs_pkg::DEF_WINDOW_REG_ADDR
) (
    input  wsrs_pkg::seq_ctrl_t           ctrl,
    input  logic [wsrs_pkg::GAP_W-1:0]    short_gap,
    input  logic [wsrs_pkg::GAP_W-1:0]    burst_gap,
    output wsrs_pkg::frame_t              frame
);
    import wsrs_pkg::*;

    localparam logic [ADDR_W-1:0] WIN_ADDR = ADDR_W'(WINDOW_REG_ADDR);

    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] addr_sum;

    // shared adder: word step for reads, plus one for the high byte
    always_comb
    begin
        case (ctrl.phase)
            S_RADDR: offset = {{(ADDR_W-IDX_W-1){1'b0}}, ctrl.idx, 1'b0};
            S_WHI:   offset = ADDR_W'(1);
            default: offset = '0;
        endcase
    end

    assign addr_sum = ctrl.addr + offset;

    // frame formatting per phase
    always_comb
    begin
        frame = '0;
        case (ctrl.phase)
            S_WIN:
            begin
                frame.word       = WRITE_FLAG | {1'b0, WIN_ADDR, ctrl.window};
                frame.kind       = KIND_WIN;
                frame.gap        = short_gap;
                frame.release_cs = 1'b1;
                frame.fin        = ctrl.win_final;
            end
            S_RADDR:
            begin
                frame.word = {1'b0, addr_sum, 8'h00};
                frame.kind = KIND_RADDR;
                frame.gap  = short_gap;
            end
            S_RDUMMY:
            begin
                frame.kind       = KIND_RDUMMY;
                frame.release_cs = 1'b1;
                frame.fin        = 1'b1;
            end
            S_WLO:
            begin
                frame.word       = WRITE_FLAG | {1'b0, addr_sum, ctrl.value[7:0]};
                frame.kind       = KIND_WRITE;
                frame.gap        = short_gap;
                frame.release_cs = !ctrl.hi_pending;
                frame.fin        = !ctrl.hi_pending;
            end
            S_WHI:
            begin
                frame.word       = WRITE_FLAG | {1'b0, addr_sum, ctrl.value[15:8]};
                frame.kind       = KIND_WRITE;
                frame.gap        = short_gap;
                frame.release_cs = 1'b1;
                frame.fin        = 1'b1;
            end
            S_BCMD:
            begin
                frame.word = WRITE_FLAG;
                frame.kind = KIND_BCMD;
                frame.gap  = burst_gap;
            end
            S_BDUMMY:
            begin
                frame.kind       = KIND_BDUMMY;
                frame.release_cs = ctrl.idx_final;
                frame.fin        = ctrl.idx_final;
            end
            default:
            begin
                frame = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/wsrs_seq.sv
// Request sequencer: window tracking, frame counter and state machine.
// Depends on wsrs_pkg and the assertion macro header.
`default_nettype none
`include "windowed_spi_register_sequencer_macros.svh"

module wsrs_seq #(
    parameter int MAX_READ_WORDS  = wsrs_pkg::DEF_MAX_READ_WORDS,
    parameter int MAX_BURST_WORDS = wsrs_pkg::DEF_MAX_BURST_WORDS,
    parameter int WINDOW_REG_ADDR = wsrs_pkg::DEF_WINDOW_REG_ADDR
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     operation,
    input  logic [wsrs_pkg::ADDR_W-1:0]    reg_addr,
    input  logic                           reg_window,
    input  logic [3:0]                     word_count,
    input  logic                           write_low_enable,
    input  logic                           write_high_enable,
    input  logic [wsrs_pkg::VALUE_W-1:0]   write_value,
    input  logic [wsrs_pkg::CNT_W-1:0]     burst_words,
    input  logic                           out_free,
    output wsrs_pkg::seq_ctrl_t            ctrl
);
    import wsrs_pkg::*;

    localparam int RD_LIM = (MAX_READ_WORDS < RUN_LIMIT) ? MAX_READ_WORDS : RUN_LIMIT;
    localparam int BU_LIM = (MAX_BURST_WORDS < RUN_LIMIT) ? MAX_BURST_WORDS : RUN_LIMIT;
    localparam logic [ADDR_W-1:0] WIN_ADDR = ADDR_W'(WINDOW_REG_ADDR);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   last_idx_reg, last_idx_next;
    op_t                op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [WIN_W-1:0]   win_sel_reg;
    logic               lo_reg, hi_reg;
    logic               window_known_reg, window_known_next;
    logic [WIN_W-1:0]   current_window_reg, current_window_next;

    op_t               op_in;
    logic              accept;
    logic              step;
    logic              is_win_reg;
    logic [WIN_W-1:0]  target_win;
    logic              win_hit;
    logic              need_win;
    logic [CNT_W-1:0]  rd_cnt, bu_cnt;
    logic [IDX_W-1:0]  rd_last, bu_last;
    logic              idx_final;

    assign op_in      = op_t'(operation);
    assign accept     = in_valid && in_ready;
    assign step       = (state_reg != S_IDLE) && out_free;
    assign is_win_reg = (reg_addr == WIN_ADDR);
    assign target_win = (op_in == OP_BURST) ? '0 : {{(WIN_W-1){1'b0}}, reg_window};
    assign win_hit    = window_known_reg && (current_window_reg == target_win);
    assign idx_final  = (idx_reg == last_idx_reg);

    // window frame needed in front of the run
    always_comb
    begin
        case (op_in)
            OP_READ, OP_WRITE: need_win = !is_win_reg && !win_hit;
            OP_BURST:          need_win = !win_hit;
            default:           need_win = 1'b0;
        endcase
    end

    // clamp read and burst lengths
    always_comb
    begin
        rd_cnt = {1'b0, word_count};
        if (rd_cnt == '0)
            rd_cnt = CNT_W'(1);
        if (rd_cnt > CNT_W'(RD_LIM))
            rd_cnt = CNT_W'(RD_LIM);
        bu_cnt = burst_words;
        if (bu_cnt == '0)
            bu_cnt = CNT_W'(1);
        if (bu_cnt > CNT_W'(BU_LIM))
            bu_cnt = CNT_W'(BU_LIM);
        rd_last = IDX_W'(rd_cnt - CNT_W'(1));
        bu_last = IDX_W'(bu_cnt - CNT_W'(1));
    end

    // next state, frame counter and window state
    always_comb
    begin
        state_next          = state_reg;
        idx_next            = idx_reg;
        last_idx_next       = last_idx_reg;
        window_known_next   = window_known_reg;
        current_window_next = current_window_reg;
        if (accept)
        begin
            idx_next      = '0;
            last_idx_next = (op_in == OP_BURST) ? bu_last : rd_last;
            if (need_win)
            begin
                window_known_next   = 1'b1;
                current_window_next = target_win;
            end
            case (op_in)
                OP_READ:
                    state_next = need_win ? S_WIN : S_RADDR;
                OP_WRITE:
                begin
                    if (is_win_reg && write_low_enable)
                    begin
                        window_known_next   = 1'b1;
                        current_window_next = write_value[7:0];
                    end
                    if (need_win)
                        state_next = S_WIN;
                    else if (write_low_enable)
                        state_next = S_WLO;
                    else if (write_high_enable)
                        state_next = S_WHI;
                    else
                        state_next = S_IDLE;
                end
                OP_BURST:
                    state_next = need_win ? S_WIN : S_BCMD;
                default:
                begin
                    window_known_next = 1'b0;
                    state_next        = S_IDLE;
                end
            endcase
        end
        else if (step)
        begin
            case (state_reg)
                S_WIN:
                begin
                    case (op_reg)
                        OP_READ:  state_next = S_RADDR;
                        OP_BURST: state_next = S_BCMD;
                        OP_WRITE:
                        begin
                            if (lo_reg)
                                state_next = S_WLO;
                            else if (hi_reg)
                                state_next = S_WHI;
                            else
                                state_next = S_IDLE;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
                S_RADDR:
                begin
                    if (idx_final)
                        state_next = S_RDUMMY;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
                S_WLO:
                    state_next = hi_reg ? S_WHI : S_IDLE;
                S_BCMD:
                    state_next = S_BDUMMY;
                S_BDUMMY:
                begin
                    if (idx_final)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
                default:
                    state_next = S_IDLE;
            endcase
        end
    end

    // outputs toward the frame unit and the input channel
    always_comb
    begin
        in_ready        = (state_reg == S_IDLE);
        ctrl.step       = step;
        ctrl.phase      = state_reg;
        ctrl.addr       = addr_reg;
        ctrl.idx        = idx_reg;
        ctrl.value      = value_reg;
        ctrl.window     = win_sel_reg;
        ctrl.win_final  = (op_reg == OP_WRITE) && !lo_reg && !hi_reg;
        ctrl.hi_pending = hi_reg;
        ctrl.idx_final  = idx_final;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            idx_reg            <= '0;
            last_idx_reg       <= '0;
            window_known_reg   <= 1'b0;
            current_window_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            idx_reg            <= idx_next;
            last_idx_reg       <= last_idx_next;
            window_known_reg   <= window_known_next;
            current_window_reg <= current_window_next;
        end
    end

    // request fields held for the run
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_in;
            addr_reg    <= reg_addr;
            value_reg   <= write_value;
            win_sel_reg <= target_win;
            lo_reg      <= write_low_enable;
            hi_reg      <= write_high_enable;
        end
    end

    // checks
    `WSRS_ASSERT(a_win_frame_known, (state_reg == S_WIN) |-> window_known_reg, "window frame with window unknown")
    `WSRS_ASSERT(a_idx_in_range, (state_reg == S_RADDR || state_reg == S_BDUMMY) |-> (idx_reg <= last_idx_reg), "frame index past run end")
    `WSRS_ASSERT(a_rdummy_ends, (step && state_reg == S_RDUMMY) |=> (state_reg == S_IDLE), "read run continues after dummy")
    `WSRS_ASSERT(a_forget_clears, (accept && op_in == OP_FORGET) |=> !window_known_reg, "forget left window known")

endmodule

`default_nettype wire

>>> src/windowed_spi_register_sequencer.sv
// Top level of the windowed SPI register sequencer: config registers,
// output register; instantiates wsrs_seq and wsrs_frame_unit (wsrs_pkg).
//
// Usage:
//   Input channel (in_valid/in_ready) takes one register request per beat:
//   read, write, burst read or forget window. Each request becomes a run of
//   16-bit SPI frames on the output channel (out_valid/out_ready), one beat
//   per frame, with kind, gap, chip-select release and last flags.
//   The sequencer emits one frame per cycle into the output register while
//   the receiver keeps up; a request yields up to 18 frames with the default
//   limits. The first frame passes the state register and then the output
//   register. A forget-window request produces no frame. Requests are taken
//   only when idle, so frame count and receiver stalls set the request rate.
//   When the receiver stalls, the sequencer holds in place; the next request
//   can be accepted while the final frame of a run still waits.
//   Reset empties the output register, selects no window (window unknown)
//   and loads gap defaults 30 and 45 ticks and burst length 8.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
//   and belong to idle periods only.
`default_nettype none

module windowed_spi_register_sequencer #(
    parameter int MAX_READ_WORDS  = wsrs_pkg::DEF_MAX_READ_WORDS,
    parameter int MAX_BURST_WORDS = wsrs_pkg::DEF_MAX_BURST_WORDS,
    parameter int WINDOW_REG_ADDR = wsrs_pkg::DEF_WINDOW_REG_ADDR
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [wsrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wsrs_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        operation,
    input  logic [6:0]                        reg_addr,
    input  logic                              reg_window,
    input  logic [3:0]                        word_count,
    input  logic                              write_low_enable,
    input  logic                              write_high_enable,
    input  logic [15:0]                       write_value,
    // frame channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [15:0]                       mosi_word,
    output logic [2:0]                        frame_kind,
    output logic [15:0]                       gap_after,
    output logic                              release_select,
    output logic                              last
);
    import wsrs_pkg::*;

    logic [GAP_W-1:0] short_gap_reg;
    logic [GAP_W-1:0] burst_gap_reg;
    logic [CNT_W-1:0] burst_words_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] mosi_word_reg;
    logic [2:0]         frame_kind_reg;
    logic [GAP_W-1:0]   gap_after_reg;
    logic               release_reg;
    logic               last_reg;

    logic      out_free;
    seq_ctrl_t ctrl;
    frame_t    frame;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_gap_reg   <= SHORT_GAP_RESET;
            burst_gap_reg   <= BURST_GAP_RESET;
            burst_words_reg <= BURST_WORDS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SHORT_GAP:   short_gap_reg   <= cfg_data;
                CFG_BURST_GAP:   burst_gap_reg   <= cfg_data;
                CFG_BURST_WORDS: burst_words_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    wsrs_seq #(
        .MAX_READ_WORDS  (MAX_READ_WORDS),
        .MAX_BURST_WORDS (MAX_BURST_WORDS),
        .WINDOW_REG_ADDR (WINDOW_REG_ADDR)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .reg_addr          (reg_addr),
        .reg_window        (reg_window),
        .word_count        (word_count),
        .write_low_enable  (write_low_enable),
        .write_high_enable (write_high_enable),
        .write_value       (write_value),
        .burst_words       (burst_words_reg),
        .out_free          (out_free),
        .ctrl              (ctrl)
    );

    wsrs_frame_unit #(
        .WINDOW_REG_ADDR (WINDOW_REG_ADDR)
    ) u_frame (
        .ctrl      (ctrl),
        .short_gap (short_gap_reg),
        .burst_gap (burst_gap_reg),
        .frame     (frame)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            mosi_word_reg  <= frame.word;
            frame_kind_reg <= frame.kind;
            gap_after_reg  <= frame.gap;
            release_reg    <= frame.release_cs;
            last_reg       <= frame.fin;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mosi_word      = mosi_word_reg;
    assign frame_kind     = frame_kind_reg;
    assign gap_after      = gap_after_reg;
    assign release_select = release_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire
